// ===== rtl/lsal_pkg.sv =====
package lsal_pkg;

   localparam int ADC_BITS_DEF = 16;
   localparam int ADC_FIELD_W  = 16;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 48;

   localparam int CYC_W   = 9;
   localparam int GAIN_W  = 3;
   localparam int LUX_W   = 30;
   localparam int SUM_W   = 32;
   localparam int SCALE_W = 15;

   // Dividing by this constant goes through a reciprocal and one correction.
   localparam int DIVISOR     = 546;
   localparam int DIV_W       = 25;
   localparam int PROD_W      = 2 * DIV_W;
   localparam int RECIP_SHIFT = 34;
   localparam int RECIP_W     = 25;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;
   localparam int REM_W       = 10;

   localparam logic [SUM_W-1:0] LUX_LIMIT = SUM_W'(400000000);

   localparam logic [ADC_FIELD_W-1:0] TH_120X = 16'd6;
   localparam logic [ADC_FIELD_W-1:0] TH_16X  = 16'd102;
   localparam logic [ADC_FIELD_W-1:0] TH_8X   = 16'd409;
   localparam logic [ADC_FIELD_W-1:0] TH_1X   = 16'd3276;

   localparam logic MODE_PROBE   = 1'b0;
   localparam logic MODE_MEASURE = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_0P16X = 3'd0;
   localparam logic [GAIN_W-1:0] GAIN_1X    = 3'd1;
   localparam logic [GAIN_W-1:0] GAIN_8X    = 3'd2;
   localparam logic [GAIN_W-1:0] GAIN_16X   = 3'd3;
   localparam logic [GAIN_W-1:0] GAIN_120X  = 3'd4;

   typedef enum logic [2:0] {
      RG_RESET,
      RG_120X,
      RG_16X,
      RG_8X,
      RG_1X,
      RG_0P16X
   } range_type;

   function automatic logic [CYC_W-1:0] range_cycles(input range_type rg);
      logic [CYC_W-1:0] c;
      unique case (rg)
         RG_RESET: c = 9'd1;
         RG_120X:  c = 9'd256;
         RG_16X:   c = 9'd128;
         default:  c = 9'd64;
      endcase
      return c;
   endfunction

   function automatic logic [GAIN_W-1:0] range_gain(input range_type rg);
      logic [GAIN_W-1:0] g;
      unique case (rg)
         RG_120X:  g = GAIN_120X;
         RG_16X:   g = GAIN_16X;
         RG_8X:    g = GAIN_8X;
         RG_0P16X: g = GAIN_0P16X;
         default:  g = GAIN_1X;
      endcase
      return g;
   endfunction

   // Lux in 1/256 units is |M| * scale / 546 for each stored setting.
   function automatic logic [SCALE_W-1:0] range_scale(input range_type rg);
      logic [SCALE_W-1:0] s;
      unique case (rg)
         RG_RESET: s = 15'd30720;
         RG_120X:  s = 15'd1;
         RG_16X:   s = 15'd15;
         RG_8X:    s = 15'd60;
         RG_1X:    s = 15'd480;
         default:  s = 15'd3000;
      endcase
      return s;
   endfunction

   typedef enum logic [2:0] {
      AO_NONE,
      AO_DIFF,
      AO_MAX,
      AO_FINISH,
      AO_PICK
   } alu_op_type;

   typedef enum logic [1:0] {
      MS_NONE,
      MS_X_RECIP,
      MS_REM_N,
      MS_QUO_N
   } mul_sel_type;

   typedef enum logic [1:0] {
      DD_NONE,
      DD_QA,
      DD_FR
   } div_dst_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_ON_ACCEPT,
      JC_IF_PROBE,
      JC_ON_SPACE
   } jump_type;

   localparam int STEP_W = 4;

   typedef struct packed {
      logic              ld_in;
      alu_op_type        alu;
      mul_sel_type       mul;
      div_dst_type       div;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ucode_word_type;

   localparam logic [STEP_W-1:0] ST_WAIT   = 4'd0;
   localparam logic [STEP_W-1:0] ST_FINISH = 4'd9;
   localparam logic [STEP_W-1:0] ST_PICK   = 4'd10;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      unique case (step)
         4'd0:    w = '{1'b1, AO_NONE,   MS_NONE,    DD_NONE, JC_ON_ACCEPT, ST_WAIT};
         4'd1:    w = '{1'b0, AO_DIFF,   MS_NONE,    DD_NONE, JC_IF_PROBE,  ST_PICK};
         4'd2:    w = '{1'b0, AO_MAX,    MS_NONE,    DD_NONE, JC_NEXT,      ST_WAIT};
         4'd3:    w = '{1'b0, AO_NONE,   MS_X_RECIP, DD_NONE, JC_NEXT,      ST_WAIT};
         4'd4:    w = '{1'b0, AO_NONE,   MS_NONE,    DD_QA,   JC_NEXT,      ST_WAIT};
         4'd5:    w = '{1'b0, AO_NONE,   MS_REM_N,   DD_NONE, JC_NEXT,      ST_WAIT};
         4'd6:    w = '{1'b0, AO_NONE,   MS_X_RECIP, DD_NONE, JC_NEXT,      ST_WAIT};
         4'd7:    w = '{1'b0, AO_NONE,   MS_NONE,    DD_FR,   JC_NEXT,      ST_WAIT};
         4'd8:    w = '{1'b0, AO_NONE,   MS_QUO_N,   DD_NONE, JC_NEXT,      ST_WAIT};
         4'd9:    w = '{1'b0, AO_FINISH, MS_NONE,    DD_NONE, JC_ON_SPACE,  ST_WAIT};
         4'd10:   w = '{1'b0, AO_PICK,   MS_NONE,    DD_NONE, JC_ON_SPACE,  ST_WAIT};
         default: w = '{1'b0, AO_NONE,   MS_NONE,    DD_NONE, JC_ON_SPACE,  ST_WAIT};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/light_sensor_autorange_lux_unit.sv =====
// Range picker and lux calculator for a two-channel ambient light sensor.
// The req channel carries one reading per transaction: tuser is the mode
// (0 = probe reading, 1 = final reading), tdata holds the two channel counts.
// The rsp channel returns one result per reading: the integration cycles and
// gain code in use, the signed lux value in 1/256 lux, and in tuser a flag
// that is set when lux was computed.
// A probe transaction picks and stores a new range: after the difference step
// the sequencer jumps to its pick step, which writes the result, and the next
// reading is taken once it is back at its wait step. A final reading runs a
// 9-step microprogram on one shared 25 x 25 multiplier and a reciprocal divide
// stage; its last step writes the result before the next reading is taken.
// Results sit in an output register, so the next reading is accepted while a
// result still waits. If that register is still full when the next result is
// ready, the sequencer holds on its last step until rsp_tready frees it.
// Reset empties the output, returns the sequencer to its wait step and sets
// the stored range to 1 integration cycle at gain 1x.
module light_sensor_autorange_lux_unit #(
   parameter int ADC_BITS = lsal_pkg::ADC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lsal_pkg::REQ_DATA_W-1:0]     req_tdata,  // adc_ch0, adc_ch1
   input  logic [0:0]                          req_tuser,  // mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lsal_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // int_cycles, gain_code, lux
   output logic [0:0]                          rsp_tuser   // lux_valid
);

   import lsal_pkg::*;

   localparam int DIFF_W = ADC_BITS + 9;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DIVISOR));

   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       mode_ff, mode_in;
   logic [ADC_BITS-1:0]        ch0_ff, ch0_in, ch1_ff, ch1_in;
   logic signed [DIFF_W-1:0]   n1_ff, n1_in, n2_ff, n2_in;
   logic                       neg_ff, neg_in;
   logic [DIV_W-1:0]           x_ff, x_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [QUO_W-1:0]           qa_ff, qa_in, fr_ff, fr_in;
   logic [REM_W-1:0]           ra_ff, ra_in;
   range_type                  range_ff, range_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CYC_W-1:0]           rsp_cycles_ff, rsp_cycles_in;
   logic [GAIN_W-1:0]          rsp_gain_ff, rsp_gain_in;
   logic signed [LUX_W-1:0]    rsp_lux_ff, rsp_lux_in;
   logic                       rsp_lux_valid_ff, rsp_lux_valid_in;

   ucode_word_type             cw;
   logic                       req_accept;
   logic                       space;
   logic                       emit;
   logic [ADC_BITS-1:0]        ch_max;
   range_type                  pick;
   logic signed [DIFF_W-1:0]   c0s, c1s, m_sel, m_abs;
   logic [DIV_W-1:0]           mul_a, mul_b;
   logic [PROD_W-1:0]          mul_p;
   logic [QUO_W-1:0]           q_est, div_quo;
   logic [DIV_W-1:0]           r_est;
   logic                       div_fix;
   logic [REM_W-1:0]           div_rem;
   logic [SUM_W-1:0]           mag_sum, mag_sat;
   logic signed [LUX_W-1:0]    lux_mag;

   assign cw         = ucode_rom(step_ff);
   assign req_tready = cw.ld_in && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign space      = !rsp_valid_ff || rsp_tready;
   assign emit       = (cw.alu == AO_FINISH || cw.alu == AO_PICK) && space;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_lux_ff, rsp_gain_ff, rsp_cycles_ff});
   assign rsp_tuser  = rsp_lux_valid_ff;

   always_comb begin
      ch_max = (ch0_ff > ch1_ff) ? ch0_ff : ch1_ff;
      if (ADC_FIELD_W'(ch_max) <= TH_120X) begin
         pick = RG_120X;
      end else if (ADC_FIELD_W'(ch_max) <= TH_16X) begin
         pick = RG_16X;
      end else if (ADC_FIELD_W'(ch_max) <= TH_8X) begin
         pick = RG_8X;
      end else if (ADC_FIELD_W'(ch_max) <= TH_1X) begin
         pick = RG_1X;
      end else begin
         pick = RG_0P16X;
      end
   end

   always_comb begin
      c0s   = signed'(DIFF_W'(ch0_ff));
      c1s   = signed'(DIFF_W'(ch1_ff));
      m_sel = (n1_ff > n2_ff) ? n1_ff : n2_ff;
      m_abs = m_sel[DIFF_W-1] ? -m_sel : m_sel;
   end

   always_comb begin
      case (cw.mul)
         MS_X_RECIP: begin
            mul_a = x_ff;
            mul_b = DIV_W'(RECIP);
         end
         MS_REM_N: begin
            mul_a = DIV_W'(ra_ff);
            mul_b = DIV_W'(range_scale(range_ff));
         end
         MS_QUO_N: begin
            mul_a = DIV_W'(qa_ff);
            mul_b = DIV_W'(range_scale(range_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // The reciprocal estimate is low by at most one, so one correction suffices.
   always_comb begin
      q_est   = prod_ff[RECIP_SHIFT +: QUO_W];
      r_est   = x_ff - DIV_W'(q_est * DIVISOR);
      div_fix = r_est >= DIV_W'(DIVISOR);
      div_quo = q_est + QUO_W'(div_fix);
      div_rem = div_fix ? REM_W'(r_est - DIV_W'(DIVISOR)) : REM_W'(r_est);
   end

   always_comb begin
      mag_sum = SUM_W'(prod_ff) + SUM_W'(fr_ff);
      mag_sat = (mag_sum > LUX_LIMIT) ? LUX_LIMIT : mag_sum;
      lux_mag = signed'(LUX_W'(mag_sat));
   end

   always_comb begin
      step_in = step_ff;
      unique case (cw.jump)
         JC_NEXT: begin
            step_in = step_ff + 1'b1;
         end
         JC_ON_ACCEPT: begin
            if (req_accept) begin
               step_in = step_ff + 1'b1;
            end
         end
         JC_IF_PROBE: begin
            step_in = (mode_ff == MODE_PROBE) ? cw.target : step_ff + 1'b1;
         end
         JC_ON_SPACE: begin
            if (space) begin
               step_in = cw.target;
            end
         end
         default: begin
            step_in = ST_WAIT;
         end
      endcase
   end

   always_comb begin
      mode_in          = mode_ff;
      ch0_in           = ch0_ff;
      ch1_in           = ch1_ff;
      n1_in            = n1_ff;
      n2_in            = n2_ff;
      neg_in           = neg_ff;
      x_in             = x_ff;
      prod_in          = prod_ff;
      qa_in            = qa_ff;
      ra_in            = ra_ff;
      fr_in            = fr_ff;
      range_in         = range_ff;
      rsp_cycles_in    = rsp_cycles_ff;
      rsp_gain_in      = rsp_gain_ff;
      rsp_lux_in       = rsp_lux_ff;
      rsp_lux_valid_in = rsp_lux_valid_ff;

      if (req_accept) begin
         mode_in = req_tuser[0];
         ch0_in  = req_tdata[ADC_BITS-1:0];
         ch1_in  = req_tdata[ADC_FIELD_W +: ADC_BITS];
      end

      if (cw.alu == AO_DIFF) begin
         n1_in = DIFF_W'(c0s * 100) - DIFF_W'(c1s * 187);
         n2_in = DIFF_W'(c0s * 63) - DIFF_W'(c1s * 100);
      end
      if (cw.alu == AO_MAX) begin
         neg_in = m_sel[DIFF_W-1];
         x_in   = DIV_W'(unsigned'(m_abs));
      end

      if (cw.mul == MS_X_RECIP || cw.mul == MS_QUO_N) begin
         prod_in = mul_p;
      end
      if (cw.mul == MS_REM_N) begin
         x_in = DIV_W'(mul_p);
      end

      if (cw.div == DD_QA) begin
         qa_in = div_quo;
         ra_in = div_rem;
      end
      if (cw.div == DD_FR) begin
         fr_in = div_quo;
      end

      if (emit && cw.alu == AO_FINISH) begin
         rsp_cycles_in    = range_cycles(range_ff);
         rsp_gain_in      = range_gain(range_ff);
         rsp_lux_in       = neg_ff ? -lux_mag : lux_mag;
         rsp_lux_valid_in = 1'b1;
      end
      if (emit && cw.alu == AO_PICK) begin
         range_in         = pick;
         rsp_cycles_in    = range_cycles(pick);
         rsp_gain_in      = range_gain(pick);
         rsp_lux_in       = '0;
         rsp_lux_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_WAIT;
         range_ff     <= RG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      ch0_ff           <= ch0_in;
      ch1_ff           <= ch1_in;
      n1_ff            <= n1_in;
      n2_ff            <= n2_in;
      neg_ff           <= neg_in;
      x_ff             <= x_in;
      prod_ff          <= prod_in;
      qa_ff            <= qa_in;
      ra_ff            <= ra_in;
      fr_ff            <= fr_in;
      rsp_cycles_ff    <= rsp_cycles_in;
      rsp_gain_ff      <= rsp_gain_in;
      rsp_lux_ff       <= rsp_lux_in;
      rsp_lux_valid_ff <= rsp_lux_valid_in;
   end

   a_one_reading_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Reading accepted while the sequencer was still busy.");

   a_result_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff) == ST_FINISH || $past(step_ff) == ST_PICK)
      else $error("Result presented from a step that does not produce one.");

   a_divide_estimate_close: assert property (@(posedge clock) disable iff (reset)
      cw.div != DD_NONE |-> r_est < DIV_W'(2 * DIVISOR))
      else $error("Reciprocal quotient estimate off by more than one.");

   a_probe_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_lux_valid_ff |-> rsp_lux_ff == '0)
      else $error("Probe result carries a nonzero lux value.");

endmodule
